// ----- hw/rtl/cbd_pkg.sv -----
// Shared types, constants and address decode for the CPU bus decoder.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

	// Default work RAM address width (2 KiB).
	localparam int RAM_ADDR_BITS_DEF = 11;

	// Bus access kinds.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Fixed addresses and masks of the memory map.
	localparam logic [15:0] PPU_REG_MASK  = 16'h0007;
	localparam logic [15:0] APU_LAST_ADDR = 16'h4013;
	localparam logic [15:0] OAM_DMA_ADDR  = 16'h4014;
	localparam logic [15:0] APU_STAT_ADDR = 16'h4015;
	localparam logic [15:0] CTRL_ADDR     = 16'h4016;
	localparam logic [15:0] APU_FRM_ADDR  = 16'h4017;
	localparam logic [2:0]  RAM_REGION    = 3'h0;
	localparam logic [2:0]  PPU_REGION    = 3'h1;
	localparam logic [3:0]  APU_PAGE      = 4'h4;

	// Upper bits driven onto the bus by a controller read.
	localparam logic [7:0] CTRL_OPEN_BITS = 8'h40;

	typedef enum logic [2:0] {
		TGT_UNMAPPED = 3'd0,
		TGT_CART     = 3'd1,
		TGT_RAM      = 3'd2,
		TGT_PPU      = 3'd3,
		TGT_APU      = 3'd4,
		TGT_DMA      = 3'd5,
		TGT_CTRL     = 3'd6
	} target_t;

	// Routes one access by fixed priority.
	function automatic target_t decode_target(input logic op, input logic [15:0] addr,
		input logic claims);
		target_t tgt;
		tgt = TGT_UNMAPPED;
		if (claims) begin
			tgt = TGT_CART;
		end else if (addr[15:13] == RAM_REGION) begin
			tgt = TGT_RAM;
		end else if (addr[15:13] == PPU_REGION) begin
			tgt = TGT_PPU;
		end else if (op == OP_WRITE) begin
			if (addr[15:12] == APU_PAGE && (addr <= APU_LAST_ADDR ||
				addr == APU_STAT_ADDR || addr == APU_FRM_ADDR)) begin
				tgt = TGT_APU;
			end else if (addr == OAM_DMA_ADDR) begin
				tgt = TGT_DMA;
			end else if (addr == CTRL_ADDR) begin
				tgt = TGT_CTRL;
			end
		end else begin
			if (addr == APU_STAT_ADDR) begin
				tgt = TGT_APU;
			end else if (addr == CTRL_ADDR) begin
				tgt = TGT_CTRL;
			end
		end
		return tgt;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpu_bus_decoder_with_ram.sv -----
// CPU bus decoder top level with internal work RAM, open-bus latch and controller port.
// An item accepted at a clock edge is held in the stage 1 registers while it is decoded,
// then its result is registered onto the outputs with done high.
// Throughput: one item per clock; busy is never raised, since the work RAM is written at
// acceptance and read into a stage 1 register for the decode stage, so no access can overlap.
// Reset (arst_n low, asynchronous): the open-bus latch, strobe flag, button shift register
// and the pipeline valid bits clear; work RAM contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module cpu_bus_decoder_with_ram
	import cbd_pkg::*;
#(
	parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        op,
	input  wire logic [15:0] addr,
	input  wire logic [7:0]  write_data,
	input  wire logic        cart_claims,
	input  wire logic [7:0]  cart_read_data,
	input  wire logic [7:0]  ppu_read_data,
	input  wire logic [7:0]  apu_read_data,
	input  wire logic [7:0]  buttons,
	output      logic        done,
	output      logic [2:0]  target,
	output      logic [15:0] device_addr,
	output      logic [7:0]  device_data,
	output      logic [7:0]  read_data
);

	localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

	// The decoder never stalls the CPU.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Work RAM. A write to the RAM region is committed at the accepting
	// edge; every access also reads the mirrored address at that edge into
	// a register for the decode stage to use. A write in one cycle
	// is thus visible to a read accepted in the next.
	// ------------------------------------------------------------------
	logic [7:0]               ram_q [RAM_DEPTH];
	logic [RAM_ADDR_BITS-1:0] ram_idx;
	logic                     ram_we;
	logic [7:0]               ram_rdata_s1;

	assign ram_idx = addr[RAM_ADDR_BITS-1:0];
	assign ram_we  = accept && (op == OP_WRITE) && !cart_claims && (addr[15:13] == RAM_REGION);

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_q[ram_idx] <= write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ram_rdata_s1 <= ram_q[ram_idx];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the accepted item is held here while it is decoded.
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic        claims_s1;
	logic [7:0]  cart_rd_s1;
	logic [7:0]  ppu_rd_s1;
	logic [7:0]  apu_rd_s1;
	logic [7:0]  buttons_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			addr_s1    <= addr;
			wdata_s1   <= write_data;
			claims_s1  <= cart_claims;
			cart_rd_s1 <= cart_read_data;
			ppu_rd_s1  <= ppu_read_data;
			apu_rd_s1  <= apu_read_data;
			buttons_s1 <= buttons;
		end
	end

	// ------------------------------------------------------------------
	// Device state: open-bus latch, controller strobe and shift register.
	// ------------------------------------------------------------------
	logic       strobe_q;
	logic [7:0] open_bus_q;
	logic [7:0] button_shift_q;

	target_t     tgt_s1;
	logic [15:0] dev_addr_d;
	logic [7:0]  dev_data_d;
	logic [7:0]  rd_d;
	logic        strobe_d;
	logic [7:0]  shift_d;

	// Decode and result selection. Writes return their own byte; a read
	// that no device answers returns the open-bus latch.
	always_comb begin
		tgt_s1     = decode_target(op_s1, addr_s1, claims_s1);
		dev_addr_d = addr_s1;
		dev_data_d = '0;
		rd_d       = open_bus_q;
		strobe_d   = strobe_q;
		shift_d    = button_shift_q;
		if (tgt_s1 == TGT_PPU) begin
			dev_addr_d = addr_s1 & PPU_REG_MASK;
		end
		if (op_s1 == OP_WRITE) begin
			dev_data_d = wdata_s1;
			rd_d       = wdata_s1;
			if (tgt_s1 == TGT_CTRL) begin
				// Strobe high reloads the buttons into the shift register.
				strobe_d = wdata_s1[0];
				if (wdata_s1[0]) begin
					shift_d = buttons_s1;
				end
			end
		end else begin
			case (tgt_s1)
				TGT_CART: rd_d = cart_rd_s1;
				TGT_RAM:  rd_d = ram_rdata_s1;
				TGT_PPU:  rd_d = ppu_rd_s1;
				TGT_APU:  rd_d = apu_rd_s1;
				TGT_CTRL: begin
					// Serial read: bit 0 of the shift register, which then
					// moves right with zeros filling in unless strobe holds it.
					rd_d = {7'b0, button_shift_q[0]} | CTRL_OPEN_BITS;
					if (!strobe_q) begin
						shift_d = {1'b0, button_shift_q[7:1]};
					end
				end
				default: rd_d = open_bus_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q       <= 1'b0;
			open_bus_q     <= '0;
			button_shift_q <= '0;
			done           <= 1'b0;
		end else begin
			done <= valid_s1;
			if (valid_s1) begin
				strobe_q       <= strobe_d;
				open_bus_q     <= rd_d;
				button_shift_q <= shift_d;
			end
		end
	end

	// Result register: one strobe per item, no back-pressure.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			target      <= tgt_s1;
			device_addr <= dev_addr_d;
			device_data <= dev_data_d;
			read_data   <= rd_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_latch_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> open_bus_q == read_data)
		else $error("open-bus latch does not hold the last returned byte");

	a_ctrl_read_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == OP_READ && tgt_s1 == TGT_CTRL && !strobe_q) |=>
		button_shift_q == {1'b0, $past(button_shift_q[7:1])})
		else $error("controller read did not shift the button register");

	a_ppu_index_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && target == TGT_PPU) |-> device_addr[15:3] == '0)
		else $error("picture unit access forwarded a wide address");

	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted item did not produce a result");

endmodule

`default_nettype wire
